FILE: hdl/irkt_pkg.sv
// Shared types, constants and controller/datapath interface structs for the IR key tracker.
package irkt_pkg;

   localparam int TABLE_ENTRIES = 8;
   localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CSR_IDX_W = 2;

   localparam logic [31:0] REPEAT_CODE = 32'hffff_ffff;
   localparam logic [15:0] REPEAT_WINDOW_RESET = 16'd300;
   localparam logic [15:0] RELEASE_TIMEOUT_RESET = 16'd500;

   typedef enum logic [1:0] {
      EV_RECEIVED = 2'd0,
      EV_PRESSED  = 2'd1,
      EV_RELEASED = 2'd2,
      EV_DROPPED  = 2'd3
   } event_kind_type;

   typedef enum logic {
      OP_CODE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REPEAT_WINDOW   = 2'd0,
      CSR_RELEASE_TIMEOUT = 2'd1
   } csr_index_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] ir_code;
   } req_item_type;

   typedef struct packed {
      event_kind_type event_kind;
      logic [31:0]    event_code;
      logic           last_of_run;
   } rsp_item_type;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_CHECK   = 6'b000010,
      ST_SCAN    = 6'b000100,
      ST_RECV    = 6'b001000,
      ST_SECOND  = 6'b010000,
      ST_RELEASE = 6'b100000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic              load;
      logic              check;
      logic              scan;
      logic              emit_recv;
      logic              emit_second;
      logic              release_step;
      logic [SLOT_W-1:0] idx;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_tick;
      logic drop;
      logic hit_found;
      logic rel_done;
   } stat_type;

endpackage

FILE: hdl/irkt_ctrl.sv
// Sequencer for the IR key tracker: walks the slot table and issues datapath commands.
module irkt_ctrl import irkt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              idx_last;

   assign idx_last = (idx_ff == SLOT_W'(TABLE_ENTRIES - 1));
   assign busy     = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.idx  = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            idx_in    = '0;
            if (!stat.is_tick && stat.drop) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (idx_last) begin
               idx_in   = '0;
               state_in = stat.is_tick ? ST_RELEASE : ST_RECV;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RECV: begin
            cmd.emit_recv = 1'b1;
            state_in      = stat.hit_found ? ST_IDLE : ST_SECOND;
         end
         ST_SECOND: begin
            cmd.emit_second = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_RELEASE: begin
            cmd.release_step = 1'b1;
            if (idx_last || stat.rel_done) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

FILE: hdl/irkt_dp.sv
// Datapath for the IR key tracker: config, time base, last code, slot table, result register.
module irkt_dp import irkt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  req_item_type         req_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata,
   output logic                 rsp_valid,
   output rsp_item_type         rsp_item
);

   logic [15:0]              window_ff, window_in;
   logic [15:0]              timeout_ff, timeout_in;
   logic [31:0]              time_ff, time_in;
   logic [31:0]              last_code_ff, last_code_in;
   logic [31:0]              last_stamp_ff, last_stamp_in;
   logic                     last_known_ff, last_known_in;
   op_type                   op_ff, op_in;
   logic [31:0]              code_ff, code_in;
   logic [31:0]              slot_code_ff [TABLE_ENTRIES];
   logic [31:0]              slot_code_in [TABLE_ENTRIES];
   logic [31:0]              slot_stamp_ff [TABLE_ENTRIES];
   logic [31:0]              slot_stamp_in [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] slot_active_ff, slot_active_in;
   logic [TABLE_ENTRIES-1:0] mask_ff, mask_in;
   logic                     hit_found_ff, hit_found_in;
   logic [SLOT_W-1:0]        hit_idx_ff, hit_idx_in;
   logic                     free_found_ff, free_found_in;
   logic [SLOT_W-1:0]        free_idx_ff, free_idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_item_type             rsp_item_ff, rsp_item_in;

   logic [31:0] gap;
   logic        rep_ok;
   logic        is_rep;
   logic [31:0] eff_code;
   logic [31:0] sel_code;
   logic [31:0] sel_stamp;
   logic        sel_active;
   logic [31:0] age;
   logic        expired;
   logic        later_marked;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // repeat code resolution
   assign gap      = time_ff - last_stamp_ff;
   assign rep_ok   = last_known_ff && (gap <= {16'd0, window_ff});
   assign is_rep   = (code_ff == REPEAT_CODE);
   assign eff_code = (is_rep && rep_ok) ? last_code_ff : code_ff;

   // slot under the sequencer index
   assign sel_code   = slot_code_ff[cmd.idx];
   assign sel_stamp  = slot_stamp_ff[cmd.idx];
   assign sel_active = slot_active_ff[cmd.idx];
   assign age        = time_ff - sel_stamp;
   assign expired    = sel_active && (age >= {16'd0, timeout_ff});

   always_comb begin
      later_marked = 1'b0;
      for (int j = 0; j < TABLE_ENTRIES; j++) begin
         if ((SLOT_W'(j) > cmd.idx) && mask_ff[j]) begin
            later_marked = 1'b1;
         end
      end
   end

   assign stat.is_tick   = (op_ff == OP_TICK);
   assign stat.drop      = is_rep && !rep_ok;
   assign stat.hit_found = hit_found_ff;
   assign stat.rel_done  = !later_marked;

   always_comb begin
      window_in      = window_ff;
      timeout_in     = timeout_ff;
      time_in        = time_ff;
      last_code_in   = last_code_ff;
      last_stamp_in  = last_stamp_ff;
      last_known_in  = last_known_ff;
      op_in          = op_ff;
      code_in        = code_ff;
      slot_code_in   = slot_code_ff;
      slot_stamp_in  = slot_stamp_ff;
      slot_active_in = slot_active_ff;
      mask_in        = mask_ff;
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      rsp_valid_in   = 1'b0;
      rsp_item_in    = rsp_item_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_REPEAT_WINDOW:   window_in  = csr_wdata;
            CSR_RELEASE_TIMEOUT: timeout_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.load) begin
         op_in   = req_item.op;
         code_in = req_item.ir_code;
         if (req_item.op == OP_TICK) begin
            time_in = time_ff + 32'd1;
         end
      end

      if (cmd.check) begin
         code_in       = eff_code;
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
         mask_in       = '0;
         if ((op_ff == OP_CODE) && !(is_rep && !rep_ok)) begin
            last_code_in  = eff_code;
            last_stamp_in = time_ff;
            last_known_in = 1'b1;
         end
      end

      if (cmd.scan) begin
         if (op_ff == OP_TICK) begin
            mask_in[cmd.idx] = expired;
         end else if (sel_active && (sel_code == code_ff)) begin
            if (!hit_found_ff) begin
               hit_found_in = 1'b1;
               hit_idx_in   = cmd.idx;
            end
         end else if (!sel_active && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmd.idx;
         end
      end

      if (cmd.emit_recv) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = '{event_kind: EV_RECEIVED, event_code: code_ff,
                          last_of_run: hit_found_ff};
         if (hit_found_ff) begin
            slot_stamp_in[hit_idx_ff] = time_ff;
         end
      end

      if (cmd.emit_second) begin
         rsp_valid_in = 1'b1;
         if (free_found_ff) begin
            slot_active_in[free_idx_ff] = 1'b1;
            slot_code_in[free_idx_ff]   = code_ff;
            slot_stamp_in[free_idx_ff]  = time_ff;
            rsp_item_in = '{event_kind: EV_PRESSED, event_code: code_ff, last_of_run: 1'b1};
         end else begin
            rsp_item_in = '{event_kind: EV_DROPPED, event_code: code_ff, last_of_run: 1'b1};
         end
      end

      if (cmd.release_step && mask_ff[cmd.idx]) begin
         rsp_valid_in             = 1'b1;
         slot_active_in[cmd.idx]  = 1'b0;
         rsp_item_in = '{event_kind: EV_RELEASED, event_code: sel_code,
                         last_of_run: !later_marked};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= REPEAT_WINDOW_RESET;
         timeout_ff     <= RELEASE_TIMEOUT_RESET;
         time_ff        <= '0;
         last_code_ff   <= '0;
         last_stamp_ff  <= '0;
         last_known_ff  <= 1'b0;
         slot_active_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_ff      <= window_in;
         timeout_ff     <= timeout_in;
         time_ff        <= time_in;
         last_code_ff   <= last_code_in;
         last_stamp_ff  <= last_stamp_in;
         last_known_ff  <= last_known_in;
         slot_active_ff <= slot_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      code_ff       <= code_in;
      slot_code_ff  <= slot_code_in;
      slot_stamp_ff <= slot_stamp_in;
      mask_ff       <= mask_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      rsp_item_ff   <= rsp_item_in;
   end

endmodule

FILE: hdl/ir_key_press_release_tracker_unit.sv
// Top level of the IR remote key press/release tracker.
//
// Input channel: a transaction is taken when start is high and busy is low.
// req_item.op selects a new IR code (OP_CODE) or a one millisecond tick
// (OP_TICK); req_item.ir_code is ignored on a tick.
// Result channel: each event appears on rsp_item for exactly one cycle with
// rsp_valid high; last_of_run marks the final event of a transaction. The
// receiver cannot stall, and the block needs no back pressure.
// Config channel: csr_index 0 = repeat window (ms), 1 = release timeout (ms);
// other indexes are ignored. csr_ready is always high; write only while idle.
// Sequence: the controller sweeps the slot table one slot per cycle.
//   Code: accept, repeat check, a scan of every slot, then a received event
//   and, when no active slot holds the code, a pressed or dropped event.
//   Tick: accept, check, an expiry scan of every slot, then a release walk
//   from slot 0 up to the last expired one (slot 0 alone if none expired).
//   A dropped repeat code returns to idle from the check with no event.
// Each event leaves a result register, so it shows in the cycle after the
// controller issues it. Reset clears time, the last code and the key table
// and loads the default window (300 ms) and timeout (500 ms).
module ir_key_press_release_tracker_unit import irkt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_item_type         req_item,
   output logic                 rsp_valid,
   output rsp_item_type         rsp_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   irkt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // registers, table and compare logic
   irkt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

`ifndef ASSERT_OFF
   // the cycle after a transaction is taken carries no event
   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("event right after accepting a transaction");

   // the final event of a run is never followed directly by another one
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last_of_run) |=> !rsp_valid)
      else $error("event directly after last_of_run");

   // pressed always follows the matching received event
   a_pressed_after_recv: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.event_kind == EV_PRESSED) |->
      ($past(rsp_valid && rsp_item.event_kind == EV_RECEIVED && !rsp_item.last_of_run) &&
       ($past(rsp_item.event_code) == rsp_item.event_code)))
      else $error("pressed event without preceding received event");
`endif

endmodule

FILE: bench/ir_key_event_checker.sv
// Checker for the IR key tracker: predicts key events and compares them with the block's results.
`timescale 1ns / 1ps

module ir_key_event_checker import irkt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  req_item_type         req_item,
   input  logic                 rsp_valid,
   input  rsp_item_type         rsp_item,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata,
   output int                   fail_count,
   output int                   events_due
);

   localparam int MAX_EVENTS = 8;

   logic [15:0] window_ms;
   logic [15:0] timeout_ms;
   logic [31:0] clock_ms;
   logic [31:0] last_code;
   logic [31:0] last_stamp;
   logic        last_seen;
   logic [31:0] key_code  [TABLE_ENTRIES];
   logic [31:0] key_stamp [TABLE_ENTRIES];
   logic        key_live  [TABLE_ENTRIES];

   rsp_item_type due_events[$];

   initial begin
      fail_count = 0;
      events_due = 0;
   end

   // Expected events of one accepted transaction, queued in order.
   task automatic predict_key_events(input req_item_type item);
      event_kind_type kinds[MAX_EVENTS];
      logic [31:0]    codes[MAX_EVENTS];
      rsp_item_type   ev;
      logic [31:0]    code;
      logic [31:0]    gap;
      int             n;
      int             hit;
      int             free_slot;
      n = 0;
      hit = -1;
      free_slot = -1;
      if (item.op == OP_CODE) begin
         code = item.ir_code;
         gap = clock_ms - last_stamp;
         if (code == REPEAT_CODE && last_seen && gap <= {16'd0, window_ms})
            code = last_code;
         if (code != REPEAT_CODE) begin
            last_code = code;
            last_stamp = clock_ms;
            last_seen = 1'b1;
            kinds[n] = EV_RECEIVED;
            codes[n] = code;
            n++;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (key_live[i] && key_code[i] == code) begin
                  if (hit < 0) hit = i;
               end else if (!key_live[i] && free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (hit >= 0) begin
               key_stamp[hit] = clock_ms;
            end else if (free_slot >= 0) begin
               key_live[free_slot] = 1'b1;
               key_code[free_slot] = code;
               key_stamp[free_slot] = clock_ms;
               kinds[n] = EV_PRESSED;
               codes[n] = code;
               n++;
            end else begin
               kinds[n] = EV_DROPPED;
               codes[n] = code;
               n++;
            end
         end
      end else begin
         clock_ms = clock_ms + 32'd1;
         for (int i = 0; i < TABLE_ENTRIES && n < MAX_EVENTS; i++) begin
            if (key_live[i] && (clock_ms - key_stamp[i]) >= {16'd0, timeout_ms}) begin
               key_live[i] = 1'b0;
               kinds[n] = EV_RELEASED;
               codes[n] = key_code[i];
               n++;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         ev.event_kind = kinds[i];
         ev.event_code = codes[i];
         ev.last_of_run = (i == n - 1);
         due_events.push_back(ev);
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         window_ms = REPEAT_WINDOW_RESET;
         timeout_ms = RELEASE_TIMEOUT_RESET;
         clock_ms = '0;
         last_code = '0;
         last_stamp = '0;
         last_seen = 1'b0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            key_code[i] = '0;
            key_stamp[i] = '0;
            key_live[i] = 1'b0;
         end
         due_events.delete();
      end else begin
         if (rsp_valid) begin
            if (due_events.size() == 0) begin
               $display("%0t: unexpected event kind=%0d code=%h last=%b", $time,
                        rsp_item.event_kind, rsp_item.event_code, rsp_item.last_of_run);
               fail_count++;
            end else begin
               want = due_events.pop_front();
               if (rsp_item.event_kind !== want.event_kind ||
                   rsp_item.event_code !== want.event_code ||
                   rsp_item.last_of_run !== want.last_of_run) begin
                  $display("%0t: event mismatch: expected kind=%0d code=%h last=%b, actual kind=%0d code=%h last=%b",
                           $time, want.event_kind, want.event_code, want.last_of_run,
                           rsp_item.event_kind, rsp_item.event_code, rsp_item.last_of_run);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_REPEAT_WINDOW) window_ms = csr_wdata;
            else if (csr_index == CSR_RELEASE_TIMEOUT) timeout_ms = csr_wdata;
         end
         if (start && !busy) predict_key_events(req_item);
      end
      events_due = due_events.size();
   end

endmodule

FILE: bench/tb_ir_key_press_release_tracker_unit.sv
// Testbench top for the IR key tracker: drives codes, ticks and register writes and gives the verdict.
`timescale 1ns / 1ps

module tb_ir_key_press_release_tracker_unit;
   import irkt_pkg::*;

   // About this many code and tick transactions, repeat codes included.
   localparam int ITEM_TARGET = 470;
   localparam int PHASE_ITEMS = 64;
   // Quiet cycles allowed before a register write and at the end; covers the
   // longest tick sweep plus the result register.
   localparam int DRAIN_CYCLES = 24;
   // Cycles with no transaction of any kind before the run is abandoned.
   localparam int STALL_LIMIT = 2000;
   // An index the block does not decode; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_item_type         req_item;
   logic                 rsp_valid;
   rsp_item_type         rsp_item;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_wdata;

   int fail_count;
   int events_due;
   int item_count;
   int stall_cycles;
   bit burst;          // no gaps at all while set
   logic [31:0] key_pool[12];

   ir_key_press_release_tracker_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ir_key_event_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .events_due (events_due)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Watchdog: restarts on every input, result or register transaction.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // One transaction on the input channel. Inputs move on the falling edge;
   // start stays high into the next call when no gap is drawn, so a
   // back-to-back item is offered without start dropping.
   task automatic send(input op_type op, input logic [31:0] code);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 55) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_item.op = op;
      req_item.ir_code = code;
      do @(posedge clock); while (busy);
      item_count++;
   endtask

   // Wait for every predicted event to arrive and the block to go quiet. A
   // dropped repeat code or an idle tick leaves nothing in the checker, so
   // the drain pause also covers work that has no visible event.
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (events_due != 0 || busy) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      settle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      int r;
      int phase;
      int phase_count;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_index = CSR_REPEAT_WINDOW;
      csr_wdata = '0;
      item_count = 0;
      stall_cycles = 0;
      burst = 1'b0;

      // Small pool so keys come back often: hits, a full table, drops.
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hffff_fffe;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7fff_ffff;
      key_pool[4] = 32'h0000_0001;
      key_pool[5] = 32'haaaa_aaaa;
      key_pool[6] = 32'h5555_5555;
      for (int i = 7; i < 12; i++) key_pool[i] = $urandom() & 32'hffff_fffe;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed part, default window 300 / timeout 500 ---
      send(OP_CODE, REPEAT_CODE);          // repeat with no code seen: dropped
      send(OP_TICK, 32'hffff_ffff);
      send(OP_CODE, 32'h0000_0000);        // fill all eight slots
      send(OP_CODE, 32'hffff_fffe);
      send(OP_CODE, 32'haaaa_aaaa);
      send(OP_CODE, 32'h5555_5555);
      send(OP_CODE, 32'h8000_0000);
      send(OP_CODE, 32'h7fff_ffff);
      send(OP_CODE, 32'h0000_0001);
      send(OP_CODE, 32'h1234_5678);
      send(OP_CODE, REPEAT_CODE);          // in window: stands for the last code
      send(OP_CODE, 32'hdead_beef);        // table full: received then dropped
      send(OP_CODE, 32'h0000_0000);        // refresh of an active key

      // Zero window and zero timeout.
      write_csr(CSR_REPEAT_WINDOW, 16'h0000);
      write_csr(CSR_RELEASE_TIMEOUT, 16'h0000);
      send(OP_CODE, REPEAT_CODE);          // gap 0 still inside a zero window
      send(OP_TICK, 32'h0000_0000);        // all eight keys released at once
      send(OP_CODE, REPEAT_CODE);          // gap 1: outside window, dropped
      send(OP_CODE, 32'hcafe_f00d);

      // Widest window and timeout.
      write_csr(CSR_REPEAT_WINDOW, 16'hffff);
      write_csr(CSR_RELEASE_TIMEOUT, 16'hffff);
      send(OP_TICK, $urandom());
      send(OP_CODE, REPEAT_CODE);
      send(OP_TICK, $urandom());

      write_csr(CSR_RELEASE_TIMEOUT, 16'h0001);
      send(OP_TICK, $urandom());           // releases the held key
      send(OP_CODE, 32'h0000_0000);
      send(OP_TICK, $urandom());
      write_csr(CSR_UNMAPPED, 16'h0001);  // must not touch either register

      // --- random part: phases with fresh settings ---
      phase = 0;
      while (item_count < ITEM_TARGET) begin
         case (phase % 5)
            0: begin
               write_csr(CSR_REPEAT_WINDOW, 16'($urandom_range(0, 15)));
               write_csr(CSR_RELEASE_TIMEOUT, 16'($urandom_range(2, 25)));
            end
            1: begin
               write_csr(CSR_REPEAT_WINDOW, 16'h0000);
               write_csr(CSR_RELEASE_TIMEOUT, 16'h0001);
            end
            2: begin
               write_csr(CSR_REPEAT_WINDOW, 16'hffff);
               write_csr(CSR_RELEASE_TIMEOUT, 16'($urandom_range(10, 60)));
            end
            3: begin
               write_csr(CSR_REPEAT_WINDOW, 16'($urandom()));
               write_csr(CSR_RELEASE_TIMEOUT, 16'hffff);
            end
            default: begin
               write_csr(CSR_REPEAT_WINDOW, 16'($urandom_range(2, 40)));
               write_csr(CSR_RELEASE_TIMEOUT, 16'h0000);
            end
         endcase
         burst = (phase % 3 == 1);
         phase_count = 0;
         while (phase_count < PHASE_ITEMS && item_count < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 45) send(OP_TICK, $urandom());
            else if (r < 62) send(OP_CODE, REPEAT_CODE);
            else if (r < 92) send(OP_CODE, key_pool[$urandom_range(0, 11)]);
            else send(OP_CODE, $urandom());
            phase_count++;
         end
         phase++;
      end

      settle();
      if (fail_count == 0 && events_due == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/irkt_pkg.sv
hdl/irkt_ctrl.sv
hdl/irkt_dp.sv
hdl/ir_key_press_release_tracker_unit.sv
bench/ir_key_event_checker.sv
bench/tb_ir_key_press_release_tracker_unit.sv
